// ===== hw/rtl/rld_pkg.sv =====
// Shared types and constants for the RMS level detector.
// Used by rld_ctrl, rld_datapath and rms_level_detector; no dependencies.
package rld_pkg;

   // Field and store widths
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int LEVEL_BITS      = 15;
   localparam int SQ_BITS         = 31;   // Q1.30 square
   localparam int FP_BITS         = 48;   // Q8.40 filtered power
   localparam int GAIN_BITS       = 31;   // Q1.30 unsigned
   localparam int COEF_BITS       = 32;   // Q2.30 signed
   localparam int FF_BITS         = 43;   // feed-forward term in Q.40
   localparam int FB_BITS         = 50;   // feedback term in Q.40
   localparam int ROOT_STEPS      = FP_BITS / 2;
   localparam int STEP_CNT_BITS   = $clog2(ROOT_STEPS);

   // CSR port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INPUT_GAIN = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FEEDBACK   = 2'd1;

   localparam logic [GAIN_BITS-1:0]        GAIN_RESET     = 31'd2543695;
   localparam logic signed [COEF_BITS-1:0] FEEDBACK_RESET = -32'sd1068654434;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_MULT,
      ST_FEEDBK,
      ST_UPDATE,
      ST_ROOT_LOAD,
      ST_ROOT_STEP,
      ST_WRITE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;     // latch the request payload
      logic square;      // square the sample
      logic mult;        // feed-forward and feedback partial products
      logic feedbk;      // combine feedback partial products
      logic update;      // new filter value and previous square
      logic root_load;   // start square root on |filtered power|
      logic root_step;   // one square root iteration
      logic load_out;    // move level into the response register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic block_end;
   } status_type;

endpackage

// ===== hw/rtl/rld_ctrl.sv =====
// Sequencer for the RMS level detector: request/response handshake,
// step order and square root iteration count. Depends on rld_pkg.
module rld_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rld_pkg::status_type status,
   output rld_pkg::cmd_type    cmd
);
   import rld_pkg::*;

   state_type                state_ff, state_in;
   logic [STEP_CNT_BITS-1:0] step_cnt_ff, step_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_SQUARE;
         ST_SQUARE:    state_in = ST_MULT;
         ST_MULT:      state_in = ST_FEEDBK;
         ST_FEEDBK:    state_in = ST_UPDATE;
         ST_UPDATE:    state_in = status.block_end ? ST_ROOT_LOAD : ST_IDLE;
         ST_ROOT_LOAD: state_in = ST_ROOT_STEP;
         ST_ROOT_STEP: begin
            if (step_cnt_ff == STEP_CNT_BITS'(ROOT_STEPS - 1)) state_in = ST_WRITE;
         end
         ST_WRITE:     if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Command outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:      cmd.capture   = req_valid;
         ST_SQUARE:    cmd.square    = 1'b1;
         ST_MULT:      cmd.mult      = 1'b1;
         ST_FEEDBK:    cmd.feedbk    = 1'b1;
         ST_UPDATE:    cmd.update    = 1'b1;
         ST_ROOT_LOAD: cmd.root_load = 1'b1;
         ST_ROOT_STEP: cmd.root_step = 1'b1;
         ST_WRITE:     cmd.load_out  = out_free;
         default:      cmd = '0;
      endcase
   end

   // Iteration counter and response valid
   always_comb begin
      step_cnt_in = step_cnt_ff;
      if (cmd.root_load) begin
         step_cnt_in = '0;
      end else if (cmd.root_step) begin
         step_cnt_in = step_cnt_ff + 1'b1;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/rld_datapath.sv =====
// Datapath of the RMS level detector: coefficient registers, squarer,
// one-pole filter arithmetic and a bit-serial square root. Depends on rld_pkg.
module rld_datapath #(
   parameter int SAMPLE_BITS = rld_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rld_pkg::cmd_type                   cmd,
   output rld_pkg::status_type                status,
   input  logic [SAMPLE_BITS-1:0]             req_sample,
   input  logic                               req_block_end,
   input  logic                               csr_we,
   input  logic [rld_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rld_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output logic [rld_pkg::LEVEL_BITS-1:0]     rsp_rms_level
);
   import rld_pkg::*;

   localparam int SQ_FRAC = 2 * (SAMPLE_BITS - 1);
   localparam int SQ_SHR  = (SQ_FRAC > 30) ? SQ_FRAC - 30 : 0;
   localparam int SQ_SHL  = (SQ_FRAC > 30) ? 0 : 30 - SQ_FRAC;
   localparam int PROD_BITS = 2 * SAMPLE_BITS;

   // Configuration
   logic [GAIN_BITS-1:0]        gain_ff;
   logic signed [COEF_BITS-1:0] fb_coef_ff;

   // Filter state
   logic [SQ_BITS-1:0]        prev_sq_ff, prev_sq_in;
   logic signed [FP_BITS-1:0] fp_ff, fp_in;

   // Working registers
   logic [SAMPLE_BITS-1:0]    sample_ff;
   logic                      block_end_ff;
   logic [SQ_BITS-1:0]        sq_ff, sq_in;
   logic [FF_BITS-1:0]        ff_ff, ff_in;
   logic signed [55:0]        pp_hi_ff, pp_hi_in;
   logic signed [56:0]        pp_lo_ff, pp_lo_in;
   logic signed [FB_BITS-1:0] fb_ff, fb_in;
   logic [FP_BITS-1:0]        rem_ff, rem_in;
   logic [FP_BITS-1:0]        root_ff, root_in;
   logic [FP_BITS-1:0]        bit_ff, bit_in;
   logic [LEVEL_BITS-1:0]     level_ff, level_in;

   logic [SAMPLE_BITS-1:0]    mag;
   logic [PROD_BITS-1:0]      sq_prod;
   logic [62:0]               ff_prod;
   logic signed [80:0]        fb_sum;
   logic signed [51:0]        y_diff;
   logic [FP_BITS:0]          trial;

   assign status.block_end = block_end_ff;
   assign rsp_rms_level    = level_ff;

   // Square of the sample magnitude, scaled to Q1.30
   always_comb begin
      mag     = sample_ff[SAMPLE_BITS-1] ? (~sample_ff + 1'b1) : sample_ff;
      sq_prod = mag * mag;
      sq_in   = SQ_BITS'((64'(sq_prod) >> SQ_SHR) << SQ_SHL);
   end

   // Feed-forward product and feedback partial products
   always_comb begin
      ff_prod  = gain_ff * ({1'b0, sq_ff} + {1'b0, prev_sq_ff});
      ff_in    = ff_prod[62:20];
      pp_hi_in = fb_coef_ff * $signed(fp_ff[47:24]);
      pp_lo_in = fb_coef_ff * $signed({1'b0, fp_ff[23:0]});
   end

   // Feedback term: floor(coef * y / 2^30)
   always_comb begin
      fb_sum = 81'($signed({pp_hi_ff, 24'd0})) + 81'(pp_lo_ff);
      fb_in  = fb_sum[79:30];
   end

   // New filter value, saturated to 48 bits
   always_comb begin
      y_diff = $signed({9'd0, ff_ff}) - 52'(fb_ff);
      if (y_diff[51:47] == 5'b00000 || y_diff[51:47] == 5'b11111) begin
         fp_in = y_diff[47:0];
      end else if (y_diff[51]) begin
         fp_in = {1'b1, {(FP_BITS-1){1'b0}}};
      end else begin
         fp_in = {1'b0, {(FP_BITS-1){1'b1}}};
      end
      prev_sq_in = sq_ff;
   end

   // Square root, one result bit per step
   always_comb begin
      trial   = {1'b0, root_ff} + {1'b0, bit_ff};
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (cmd.root_load) begin
         rem_in  = fp_ff[FP_BITS-1] ? (~fp_ff + 1'b1) : fp_ff;
         root_in = '0;
         bit_in  = {2'b01, {(FP_BITS-2){1'b0}}};
      end else if (cmd.root_step) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in  = rem_ff - trial[FP_BITS-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   // Level: root / 32, saturated
   always_comb begin
      if (|root_ff[FP_BITS-1:LEVEL_BITS+5]) begin
         level_in = {LEVEL_BITS{1'b1}};
      end else begin
         level_in = root_ff[LEVEL_BITS+4:5];
      end
   end

   // Configuration and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= GAIN_RESET;
         fb_coef_ff <= FEEDBACK_RESET;
         prev_sq_ff <= '0;
         fp_ff      <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_INPUT_GAIN: gain_ff    <= csr_wdata[GAIN_BITS-1:0];
               CSR_FEEDBACK:   fb_coef_ff <= $signed(csr_wdata);
               default:        ;
            endcase
         end
         if (cmd.update) begin
            prev_sq_ff <= prev_sq_in;
            fp_ff      <= fp_in;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff    <= req_sample;
         block_end_ff <= req_block_end;
      end
      if (cmd.square) sq_ff <= sq_in;
      if (cmd.mult) begin
         ff_ff    <= ff_in;
         pp_hi_ff <= pp_hi_in;
         pp_lo_ff <= pp_lo_in;
      end
      if (cmd.feedbk)   fb_ff    <= fb_in;
      if (cmd.load_out) level_ff <= level_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

endmodule

// ===== hw/rtl/rms_level_detector.sv =====
// Top level of the RMS level detector: rld_ctrl sequencer plus rld_datapath.
// Depends on rld_pkg, rld_ctrl and rld_datapath.
//
// Usage:
//  - req_*: one signed audio sample per request, with req_block_end marking
//    the last sample of an analysis block. Each request updates a one-pole
//    filter of the squared samples.
//  - rsp_*: one response (rsp_rms_level) per request that has block_end set;
//    requests without it give no response.
//  - csr_*: coefficient writes, index 0 = input gain, 1 = feedback; always
//    ready, other indexes are ignored. Write only while the block is idle.
// Timing:
//  - A request without block_end occupies the block through accept, square,
//    products, feedback sum and filter update, in that order.
//  - A request with block_end adds the square root, one result bit per cycle,
//    then writes the level once a held response is taken; rsp_valid rises in
//    the same cycle that req_ready returns for the next request.
// Reset clears the filter state, loads the default coefficients and empties
// the response register. A stalled receiver holds the response in its
// register; further requests are still taken, and only a second level waits.
module rms_level_detector #(
   parameter int SAMPLE_BITS = rld_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [SAMPLE_BITS-1:0]             req_sample,
   input  logic                               req_block_end,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rld_pkg::LEVEL_BITS-1:0]     rsp_rms_level,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rld_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rld_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import rld_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   rld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rld_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_sample    (req_sample),
      .req_block_end (req_block_end),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_rms_level (rsp_rms_level)
   );

`ifndef SYNTHESIS
   // Block is busy right after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one in flight");

   // At most one datapath step per cycle
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.square, cmd.mult, cmd.feedbk, cmd.update,
                cmd.root_load, cmd.root_step, cmd.load_out}))
      else $error("overlapping datapath commands");

   // Response register never overwritten while held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || rsp_ready))
      else $error("pending response overwritten");

   // Square root always follows a filter update
   a_root_order: assert property (@(posedge clock) disable iff (reset)
      cmd.root_load |-> $past(cmd.update))
      else $error("square root started out of order");
`endif

endmodule
